// ----- design/xsr_pkg.sv -----
// ----------------------------------------------------------------------------
// xsr_pkg: shared types and constants of the xorshift128 ranged generator
// Request and result structures, command codes, seeds and shift amounts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xsr_pkg;

	localparam int unsigned WORD_W = 32;

	localparam logic [WORD_W-1:0] SEED_A = 32'd123456789;
	localparam logic [WORD_W-1:0] SEED_B = 32'd362436069;
	localparam logic [WORD_W-1:0] SEED_C = 32'd521288629;
	localparam logic [WORD_W-1:0] SEED_D = 32'd88675123;

	localparam int unsigned SHL_T = 11;
	localparam int unsigned SHR_D = 19;
	localparam int unsigned SHR_T = 8;

	localparam logic CMD_RAW    = 1'b0;
	localparam logic CMD_RANGED = 1'b1;

	typedef struct packed {
		logic                     command;
		logic signed [WORD_W-1:0] lower_bound;
		logic signed [WORD_W-1:0] upper_bound;
	} req_t;

	typedef struct packed {
		logic        [WORD_W-1:0] raw_word;
		logic signed [WORD_W-1:0] ranged_value;
	} rsp_t;

endpackage

`default_nettype wire

// ----- design/xorshift128_ranged_rng.sv -----
// ----------------------------------------------------------------------------
// xorshift128_ranged_rng: a raw or equal-bound request passes through ST_HOLD to
// the result register, a ranged one through ST_DIV and then ST_HOLD; one request
// in flight: no new request is taken until the last result is registered.
// The ranged remainder is a restoring divider that retires one bit per cycle.
// Async reset loads the published seeds and leaves both channels empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xorshift128_ranged_rng (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire xsr_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output xsr_pkg::rsp_t      rsp
);
	import xsr_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] word_a_q, word_b_q, word_c_q, word_d_q;
	logic [WORD_W-1:0] raw_q;
	logic [WORD_W-1:0] div_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] span_q;
	logic [WORD_W-1:0] lo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [WORD_W-1:0] t_word;
	logic [WORD_W-1:0] next_d;
	logic [WORD_W-1:0] span;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] rem_next;

	always_comb begin
		t_word = word_a_q ^ (word_a_q << SHL_T);
		next_d = word_d_q ^ (word_d_q >> SHR_D) ^ t_word ^ (t_word >> SHR_T);
		span   = $unsigned(req.upper_bound) - $unsigned(req.lower_bound);
	end

	// One restoring step: bring in the next dividend bit and subtract the span
	// whenever the partial remainder reaches it.
	always_comb begin
		shifted  = {rem_q, div_q[WORD_W-1]};
		diff     = shifted - {1'b0, span_q};
		rem_next = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			word_a_q    <= SEED_A;
			word_b_q    <= SEED_B;
			word_c_q    <= SEED_C;
			word_d_q    <= SEED_D;
			raw_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			span_q      <= '0;
			lo_q        <= '0;
			cnt_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In ST_HOLD the result register is reloaded below instead.
			if (rsp_valid_q && !rsp_stall && (state_q != ST_HOLD)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						rem_q <= '0;
						unique case (req.command)
							CMD_RAW: begin
								word_a_q <= word_b_q;
								word_b_q <= word_c_q;
								word_c_q <= word_d_q;
								word_d_q <= next_d;
								raw_q    <= next_d;
								lo_q     <= '0;
								state_q  <= ST_HOLD;
							end
							CMD_RANGED: begin
								lo_q <= $unsigned(req.lower_bound);
								if (req.lower_bound == req.upper_bound) begin
									// Equal bounds leave the generator untouched.
									raw_q   <= '0;
									state_q <= ST_HOLD;
								end else begin
									word_a_q <= word_b_q;
									word_b_q <= word_c_q;
									word_c_q <= word_d_q;
									word_d_q <= next_d;
									raw_q    <= next_d;
									div_q    <= next_d;
									span_q   <= span;
									cnt_q    <= CNT_W'(WORD_W - 1);
									state_q  <= ST_DIV;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					div_q <= div_q << 1;
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_HOLD: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.raw_word     <= raw_q;
						rsp_q.ranged_value <= $signed(rem_q + lo_q);
						rsp_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/xsr_checker.sv -----
// ----------------------------------------------------------------------------
// xsr_checker: port-level checks for the xorshift128 ranged generator
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsr_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire xsr_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire xsr_pkg::rsp_t rsp
);
	import xsr_pkg::*;

	// A stalled result stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed or vanished while stalled");

	// A result leaves only through a completed transfer.
	a_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(!rsp_stall))
		else $error("result dropped without a transfer");

	// Only one request is in flight, so an accepted transfer closes the input.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	// A new result only appears once a request has been worked on.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a request in flight");

endmodule

bind xorshift128_ranged_rng xsr_checker u_xsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the xorshift128 ranged generator
// Sends raw and ranged requests with random gaps and back-pressure. A model of
// the four state words predicts every result, and each result that arrives is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import xsr_pkg::*;

	localparam int RANDOM_ITEMS = 1100;
	localparam int MAX_REPORTS  = 10;

	// Tracks the generator state and the results still owed by the block.
	class xorshift_tracker;
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
		logic [WORD_W-1:0] word_c;
		logic [WORD_W-1:0] word_d;
		rsp_t              owed_results[$];
		int                mismatches;

		function new();
			word_a = SEED_A;
			word_b = SEED_B;
			word_c = SEED_C;
			word_d = SEED_D;
			mismatches = 0;
		endfunction

		function logic [WORD_W-1:0] next_word();
			logic [WORD_W-1:0] t;
			t = word_a ^ (word_a << SHL_T);
			word_a = word_b;
			word_b = word_c;
			word_c = word_d;
			word_d = word_d ^ (word_d >> SHR_D) ^ t ^ (t >> SHR_T);
			return word_d;
		endfunction

		function void note_request(req_t item);
			rsp_t              want;
			logic [WORD_W-1:0] span;
			want = '0;
			if (item.command == CMD_RAW) begin
				want.raw_word = next_word();
			end else if (item.lower_bound == item.upper_bound) begin
				// Equal bounds return the lower bound and leave the state alone.
				want.ranged_value = item.lower_bound;
			end else begin
				span = item.upper_bound - item.lower_bound;
				want.raw_word = next_word();
				want.ranged_value = (want.raw_word % span) + item.lower_bound;
			end
			owed_results.push_back(want);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result %h arrived with nothing pending", $realtime, got);
				return;
			end
			want = owed_results.pop_front();
			if (got.raw_word !== want.raw_word || got.ranged_value !== want.ranged_value) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: raw_word exp %h got %h, ranged_value exp %h got %h",
						$realtime, want.raw_word, got.raw_word,
						want.ranged_value, got.ranged_value);
			end
		endfunction

		function int pending();
			return owed_results.size();
		endfunction
	endclass

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	xorshift_tracker sb = new();

	// When set, neither side inserts gaps or stalls.
	bit quiet = 1'b0;
	int stall_left = 0;

	xorshift128_ranged_rng DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [WORD_W-1:0] pick_bound();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0000_0001;
		endcase
	endfunction

	function automatic req_t random_request();
		req_t item;
		int   kind;
		item.command = $urandom_range(0, 1) ? CMD_RANGED : CMD_RAW;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			item.lower_bound = $urandom();
			item.upper_bound = item.lower_bound;
		end else if (kind < 50) begin
			item.lower_bound = $urandom();
			item.upper_bound = $urandom();
		end else if (kind < 80) begin
			item.lower_bound = $urandom();
			item.upper_bound = item.lower_bound + $urandom_range(1, 16);
		end else begin
			item.lower_bound = pick_bound();
			item.upper_bound = pick_bound();
		end
		return item;
	endfunction

	function automatic req_t make_request(logic cmd, logic [WORD_W-1:0] lo,
			logic [WORD_W-1:0] hi);
		req_t item;
		item.command = cmd;
		item.lower_bound = lo;
		item.upper_bound = hi;
		return item;
	endfunction

	task automatic send_request(input req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(item);
	endtask

	// Holds off the sender until every outstanding result has been taken.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(CMD_RAW, 32'h0, 32'h0));
		send_request(make_request(CMD_RAW, 32'h8000_0000, 32'h7fff_ffff));
		send_request(make_request(CMD_RANGED, 32'h8000_0000, 32'h8000_0000));
		send_request(make_request(CMD_RANGED, 32'h7fff_ffff, 32'h7fff_ffff));
		send_request(make_request(CMD_RANGED, 32'h0, 32'h0));
		send_request(make_request(CMD_RANGED, 32'h0, 32'h1));
		send_request(make_request(CMD_RANGED, 32'h8000_0000, 32'h7fff_ffff));
		// Upper bound below lower bound: the span wraps around.
		send_request(make_request(CMD_RANGED, 32'h7fff_ffff, 32'h8000_0000));
		send_request(make_request(CMD_RANGED, 32'h0, 32'h8000_0000));
		send_request(make_request(CMD_RANGED, 32'hffff_ffff, 32'h0));
		send_request(make_request(CMD_RANGED, 32'h1, 32'h0));
		send_request(make_request(CMD_RANGED, 32'd5, -32'sd5));
		send_request(make_request(CMD_RANGED, -32'sd100, 32'd100));
		send_request(make_request(CMD_RANGED, 32'h0, 32'h2));
		send_request(make_request(CMD_RANGED, 32'h7fff_fffe, 32'h7fff_ffff));
		send_request(make_request(CMD_RANGED, 32'h8000_0000, 32'h8000_0001));
		send_request(make_request(CMD_RAW, 32'hffff_ffff, 32'hffff_ffff));
		send_request(make_request(CMD_RANGED, 32'h0, 32'hffff_ffff));
		wait_for_drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 49) == 0)
				quiet = ~quiet;
			if ($urandom_range(0, 199) == 0)
				wait_for_drain();
			send_request(random_request());
		end

		quiet = 1'b0;
		wait_for_drain();
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/xsr_pkg.sv
design/xorshift128_ranged_rng.sv
design/xsr_checker.sv
dv/tb_top.sv
